[rtl/pushb_pkg.sv]
`default_nettype none
package pushb_pkg;

  localparam int MAX_USERS     = 4;
  localparam int HISTORY_DEPTH = 16;

  localparam int ID_W     = 8;
  localparam int SAMPLE_W = 10;
  localparam int POS_W    = 4;
  localparam int CODE_W   = 3;

  localparam int UW        = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int CW        = $clog2(MAX_USERS + 1);
  localparam int HW        = $clog2(HISTORY_DEPTH);
  localparam int FW        = $clog2(HISTORY_DEPTH + 1);
  localparam int MEM_DEPTH = MAX_USERS * HISTORY_DEPTH;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CODE_W-1:0] {
    RC_STORED     = 3'd0,
    RC_STORED_NEW = 3'd1,
    RC_DROPPED    = 3'd2,
    RC_HISTORY    = 3'd3,
    RC_NO_USERS   = 3'd4
  } result_code_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RADDR,
    B_RDATA
  } back_state_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic                             is_read;
    result_code_t                     code;
    logic [ID_W-1:0]                  id;
    logic [POS_W-1:0]                 pos;
    logic [SAMPLE_W-1:0]              value;
    logic                             wr_en;
    logic [AW-1:0]                    addr;
    logic [CW-1:0]                    rd_count;
    logic [MAX_USERS-1:0][ID_W-1:0]   rd_ids;
    logic [MAX_USERS-1:0][HW-1:0]     rd_oldest;
  } cmd_t;

  // ring offset to the 4-bit position field, zero-extended or masked
  function automatic logic [POS_W-1:0] to_pos(input logic [HW-1:0] j);
    logic [HW+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, j};
    return t[POS_W-1:0];
  endfunction

  // (a + b) mod HISTORY_DEPTH for a, b below HISTORY_DEPTH
  function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] a,
                                              input logic [HW-1:0] b);
    logic [HW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (HW+1)'(HISTORY_DEPTH)) begin
      s = s - (HW+1)'(HISTORY_DEPTH);
    end
    return s[HW-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/pushb_in_if.sv]
`default_nettype none
interface pushb_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [pushb_pkg::ID_W-1:0]     user_id;
  logic [pushb_pkg::SAMPLE_W-1:0] sample;
  logic                          batch_last;

  modport source (output valid, action, user_id, sample, batch_last, input ready);
  modport sink (input valid, action, user_id, sample, batch_last, output ready);
endinterface
`default_nettype wire

[rtl/pushb_out_if.sv]
`default_nettype none
interface pushb_out_if;
  logic                          valid;
  logic                          ready;
  logic [pushb_pkg::CODE_W-1:0]   result_code;
  logic [pushb_pkg::ID_W-1:0]     owner_id;
  logic [pushb_pkg::POS_W-1:0]    position;
  logic [pushb_pkg::SAMPLE_W-1:0] value;
  logic                          last;

  modport source (output valid, result_code, owner_id, position, value, last,
                  input ready);
  modport sink (input valid, result_code, owner_id, position, value, last,
                output ready);
endinterface
`default_nettype wire

[rtl/pushb_front.sv]
`default_nettype none
module pushb_front (
  input  wire logic           clk,
  input  wire logic           rst,
  pushb_in_if.sink            req,
  output pushb_pkg::cmd_t     cmd,
  output logic                cmd_valid,
  input  wire logic           cmd_ready
);
  import pushb_pkg::*;

  logic [MAX_USERS-1:0][ID_W-1:0] user_ids;
  logic [MAX_USERS-1:0][HW-1:0]   oldest_index;
  logic [MAX_USERS-1:0][FW-1:0]   fill_count;
  logic [CW-1:0]                  user_count;

  logic            found;
  logic [UW-1:0]   slot;
  logic            new_user;
  logic            drop;
  logic [HW-1:0]   cur_oldest;
  logic [FW-1:0]   cur_fill;
  logic [HW-1:0]   wr_idx;
  logic [HW-1:0]   oldest_next;
  logic [FW-1:0]   fill_next;
  logic [HW-1:0]   pos_idx;
  logic            accept;

  assign cmd_valid = req.valid;
  assign req.ready = cmd_ready;
  assign accept    = req.valid && cmd_ready;

  always_comb begin
    found = 1'b0;
    slot  = UW'(user_count);
    for (int u = 0; u < MAX_USERS; u++) begin
      if (!found && (CW'(u) < user_count) && (user_ids[u] == req.user_id)) begin
        found = 1'b1;
        slot  = UW'(u);
      end
    end
    new_user = !found && (user_count != CW'(MAX_USERS));
    drop     = !found && (user_count == CW'(MAX_USERS));

    cur_oldest = new_user ? '0 : oldest_index[slot];
    cur_fill   = new_user ? '0 : fill_count[slot];

    if (cur_fill < FW'(HISTORY_DEPTH)) begin
      wr_idx      = ring_add(cur_oldest, HW'(cur_fill));
      oldest_next = cur_oldest;
      fill_next   = cur_fill + FW'(1);
      pos_idx     = HW'(cur_fill);
    end else begin
      // ring full: overwrite the oldest and move it on
      wr_idx      = cur_oldest;
      oldest_next = ring_add(cur_oldest, HW'(1));
      fill_next   = cur_fill;
      pos_idx     = HW'(HISTORY_DEPTH - 1);
    end

    cmd.is_read   = req.action;
    cmd.id        = req.user_id;
    cmd.value     = req.sample;
    cmd.wr_en     = !req.action && !drop;
    cmd.addr      = AW'(slot) * AW'(HISTORY_DEPTH) + AW'(wr_idx);
    cmd.rd_count  = user_count;
    cmd.rd_ids    = user_ids;
    cmd.rd_oldest = oldest_index;
    if (drop) begin
      cmd.code = RC_DROPPED;
      cmd.pos  = '0;
    end else begin
      cmd.code = new_user ? RC_STORED_NEW : RC_STORED;
      cmd.pos  = to_pos(pos_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_ids     <= '0;
      oldest_index <= '0;
      fill_count   <= '0;
      user_count   <= '0;
    end else if (accept && !req.action && !drop) begin
      if (new_user) begin
        user_ids[slot] <= req.user_id;
        user_count     <= user_count + CW'(1);
      end
      oldest_index[slot] <= oldest_next;
      fill_count[slot]   <= fill_next;
    end
  end

endmodule
`default_nettype wire

[rtl/pushb_queue.sv]
`default_nettype none
module pushb_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pushb_pkg::cmd_t wr_cmd,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  output pushb_pkg::cmd_t      rd_cmd,
  output logic                 rd_valid,
  input  wire logic            rd_ready
);
  import pushb_pkg::*;

  cmd_t           entries [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;

  assign wr_ready = (count != QCW'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/pushb_back.sv]
`default_nettype none
module pushb_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pushb_pkg::cmd_t cmd,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  pushb_out_if.source          res
);
  import pushb_pkg::*;

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] written;
  logic [SAMPLE_W-1:0] mem_q;
  logic                written_q;

  back_state_t state;
  back_state_t state_next;

  logic [CW-1:0]                  rd_count;
  logic [MAX_USERS-1:0][ID_W-1:0] rd_ids;
  logic [MAX_USERS-1:0][HW-1:0]   rd_oldest;
  logic [UW-1:0]                  cur_user;
  logic [HW-1:0]                  cur_pos;

  logic                out_free;
  logic                out_load;
  result_code_t        out_code;
  logic [ID_W-1:0]     out_owner;
  logic [POS_W-1:0]    out_pos;
  logic [SAMPLE_W-1:0] out_value;
  logic                out_last;
  logic                mem_we;
  logic                rd_en;
  logic                snap_load;
  logic                walk_step;
  logic                walk_done;
  logic [AW-1:0]       rd_addr;

  assign out_free  = !res.valid || res.ready;
  assign walk_done = ((CW'(cur_user) + CW'(1)) == rd_count) &&
                     (cur_pos == HW'(HISTORY_DEPTH - 1));
  assign rd_addr   = AW'(cur_user) * AW'(HISTORY_DEPTH) +
                     AW'(ring_add(rd_oldest[cur_user], cur_pos));

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    out_load   = 1'b0;
    out_code   = cmd.code;
    out_owner  = cmd.id;
    out_pos    = cmd.pos;
    out_value  = cmd.value;
    out_last   = 1'b1;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    snap_load  = 1'b0;
    walk_step  = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          if (!cmd.is_read) begin
            out_load = 1'b1;
            mem_we   = cmd.wr_en;
          end else if (cmd.rd_count == '0) begin
            out_load  = 1'b1;
            out_code  = RC_NO_USERS;
            out_owner = '0;
            out_pos   = '0;
            out_value = '0;
          end else begin
            snap_load  = 1'b1;
            state_next = B_RADDR;
          end
        end
      end
      B_RADDR: begin
        rd_en      = 1'b1;
        state_next = B_RDATA;
      end
      B_RDATA: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_code  = RC_HISTORY;
          out_owner = rd_ids[cur_user];
          out_pos   = to_pos(cur_pos);
          // slots never written since reset read zero
          out_value = written_q ? mem_q : '0;
          out_last  = walk_done;
          walk_step = 1'b1;
          state_next = walk_done ? B_IDLE : B_RADDR;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.addr] <= cmd.value;
    end
    if (rd_en) begin
      mem_q     <= mem[rd_addr];
      written_q <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (mem_we) begin
      written[cmd.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      rd_count  <= cmd.rd_count;
      rd_ids    <= cmd.rd_ids;
      rd_oldest <= cmd.rd_oldest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_user <= '0;
      cur_pos  <= '0;
    end else if (snap_load) begin
      cur_user <= '0;
      cur_pos  <= '0;
    end else if (walk_step) begin
      if (cur_pos == HW'(HISTORY_DEPTH - 1)) begin
        cur_pos  <= '0;
        cur_user <= cur_user + UW'(1);
      end else begin
        cur_pos <= cur_pos + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.result_code <= out_code;
      res.owner_id    <= out_owner;
      res.position    <= out_pos;
      res.value       <= out_value;
      res.last        <= out_last;
    end
  end

endmodule
`default_nettype wire

[rtl/per_user_sample_history_buffer.sv]
`default_nettype none
// Per-user sample history buffer. Up to MAX_USERS users (in order of first
// push) each keep a ring of the last HISTORY_DEPTH samples. A push request
// (action 0) gives one result: stored, stored as new user, or dropped when the
// table is full. A read request (action 1) gives HISTORY_DEPTH results per
// user, oldest first, last set on the final one, or a single no-users result.
// The front end classifies one request per cycle into a two-entry queue while
// the queue has room; the back end gives a push result straight from its idle
// state, and each history result passes an address state and then a registered
// sample store read. The back end waits while the last result is not taken.
// No clearing pass after reset: per-slot written flags make unwritten slots
// read zero.
module per_user_sample_history_buffer (
  input  wire logic clk,
  input  wire logic rst,
  pushb_in_if.sink  req,
  pushb_out_if.source res
);
  import pushb_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  pushb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  pushb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  pushb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .res       (res)
  );

endmodule
`default_nettype wire

[test/history_tb_pkg.sv]
`default_nettype none
package history_tb_pkg;

  // encoding of the action field of a request
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_READ = 1'b1;

endpackage
`default_nettype wire

[test/history_checker.sv]
`default_nettype none
module history_checker (
  input  wire logic clk,
  input  wire logic rst,
  pushb_in_if  req,
  pushb_out_if res,
  output int   fail_count,
  output int   pending,
  output int   results_checked,
  output int   drops_seen,
  output int   overwrites
);
  import pushb_pkg::*;
  import history_tb_pkg::*;

  typedef struct packed {
    result_code_t          code;
    logic [ID_W-1:0]       owner;
    logic [POS_W-1:0]      pos;
    logic [SAMPLE_W-1:0]   val;
    logic                  last;
  } hist_result_t;

  logic [ID_W-1:0]     user_table [MAX_USERS];
  int                  n_users;
  logic [SAMPLE_W-1:0] ring_mem [MEM_DEPTH];
  int                  oldest [MAX_USERS];
  int                  fill [MAX_USERS];
  hist_result_t        expected_results [$];

  function automatic void predict_request(input logic act, input logic [ID_W-1:0] id,
                                          input logic [SAMPLE_W-1:0] smp);
    int           slot;
    int           wr;
    hist_result_t r;
    r = '0;
    if (act == ACT_PUSH) begin
      slot = n_users;
      for (int u = n_users - 1; u >= 0; u--) begin
        if (user_table[u] == id) slot = u;
      end
      r.owner = id;
      r.val   = smp;
      r.last  = 1'b1;
      if (slot == n_users && n_users >= MAX_USERS) begin
        r.code = RC_DROPPED;
        drops_seen++;
      end else begin
        r.code = RC_STORED;
        if (slot == n_users) begin
          user_table[slot] = id;
          oldest[slot]     = 0;
          fill[slot]       = 0;
          n_users++;
          r.code = RC_STORED_NEW;
        end
        if (fill[slot] < HISTORY_DEPTH) begin
          wr = (oldest[slot] + fill[slot]) % HISTORY_DEPTH;
          ring_mem[slot * HISTORY_DEPTH + wr] = smp;
          fill[slot]++;
        end else begin
          // ring full: newest replaces oldest
          wr = oldest[slot];
          ring_mem[slot * HISTORY_DEPTH + wr] = smp;
          oldest[slot] = (wr + 1) % HISTORY_DEPTH;
          overwrites++;
        end
        r.pos = POS_W'(fill[slot] - 1);
      end
      expected_results.push_back(r);
    end else if (n_users == 0) begin
      r.code = RC_NO_USERS;
      r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int u = 0; u < n_users; u++) begin
        for (int j = 0; j < HISTORY_DEPTH; j++) begin
          r.code  = RC_HISTORY;
          r.owner = user_table[u];
          r.pos   = POS_W'(j);
          r.val   = ring_mem[u * HISTORY_DEPTH + (oldest[u] + j) % HISTORY_DEPTH];
          r.last  = (u == n_users - 1) && (j == HISTORY_DEPTH - 1);
          expected_results.push_back(r);
        end
      end
    end
  endfunction

  task automatic report(input string what, input hist_result_t want, input hist_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: expected code %0d owner %02h pos %0d value %0d last %0b, got code %0d owner %02h pos %0d value %0d last %0b",
               $realtime, what, want.code, want.owner, want.pos, want.val, want.last,
               got.code, got.owner, got.pos, got.val, got.last);
    end
  endtask

  task automatic check_result();
    hist_result_t want;
    hist_result_t got;
    got.code  = result_code_t'(res.result_code);
    got.owner = res.owner_id;
    got.pos   = res.position;
    got.val   = res.value;
    got.last  = res.last;
    if (expected_results.size() == 0) begin
      report("result with nothing pending", '0, got);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (want.code !== got.code || want.owner !== got.owner || want.pos !== got.pos ||
          want.val !== got.val || want.last !== got.last) begin
        report("result mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      n_users         = 0;
      fail_count      = 0;
      results_checked = 0;
      drops_seen      = 0;
      overwrites      = 0;
      expected_results.delete();
      for (int u = 0; u < MAX_USERS; u++) begin
        user_table[u] = '0;
        oldest[u]     = 0;
        fill[u]       = 0;
      end
      for (int a = 0; a < MEM_DEPTH; a++) ring_mem[a] = '0;
    end else begin
      // prediction first so a same-edge result still pairs with the oldest entry
      if (req.valid && req.ready) predict_request(req.action, req.user_id, req.sample);
      if (res.valid && res.ready) check_result();
    end
    pending <= expected_results.size();
  end

endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
  import pushb_pkg::*;
  import history_tb_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int HOLD_CYCLES  = 400;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   hold_go;
  int   n_pushes;
  int   n_reads;
  int   fail_count;
  int   pending;
  int   results_checked;
  int   drops_seen;
  int   overwrites;

  logic [ID_W-1:0] user_pool [MAX_USERS] = '{8'h00, 8'hFF, 8'h55, 8'hAA};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pushb_in_if  req_ch ();
  pushb_out_if res_ch ();

  per_user_sample_history_buffer u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  history_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .res             (res_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .drops_seen      (drops_seen),
    .overwrites      (overwrites)
  );

  task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                              input logic [SAMPLE_W-1:0] smp, input logic bl);
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.user_id    <= id;
    req_ch.sample     <= smp;
    req_ch.batch_last <= bl;
    do @(posedge clk); while (!req_ch.ready);
    if (act == ACT_READ) n_reads++;
    else n_pushes++;
  endtask

  task automatic random_request();
    int               pick;
    int               sel;
    logic [ID_W-1:0]  id;
    logic [SAMPLE_W-1:0] smp;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    // mostly registered users so rings wrap, some unknown ids to hit the full table
    if (pick < 80) id = user_pool[$urandom_range(0, MAX_USERS - 1)];
    else id = ID_W'($urandom_range(0, 255));
    if (sel == 0) smp = '0;
    else if (sel == 1) smp = '1;
    else smp = SAMPLE_W'($urandom_range(0, 1023));
    send_request((pick < 10) ? ACT_READ : ACT_PUSH, id, smp, 1'($urandom_range(0, 1)));
  endtask

  // receiver: shifting ready patterns plus one long hold-off
  initial begin
    int       tick;
    int       hold_left;
    bit       held;
    rx_mode_t mode;
    tick      = 0;
    hold_left = 0;
    held      = 1'b0;
    mode      = RX_OPEN;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tick % 48 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   res_ch.ready <= 1'b1;
          RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   res_ch.ready <= (tick % 8 < 5);
        endcase
      end
    end
  end

  initial begin
    #10000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n_random;
    int burst;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_PUSH;
    req_ch.user_id    <= '0;
    req_ch.sample     <= '0;
    req_ch.batch_last <= 1'b0;
    hold_go           <= 1'b0;
    n_pushes = 0;
    n_reads  = 0;
    n_random = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table, then tables of one and two users, then a full table
    send_request(ACT_READ, 8'h00, 10'd0, 1'b0);
    send_request(ACT_PUSH, 8'h00, 10'd0, 1'b0);
    send_request(ACT_READ, 8'hFF, 10'h3FF, 1'b1);
    send_request(ACT_PUSH, 8'hFF, 10'h3FF, 1'b1);
    send_request(ACT_PUSH, 8'h00, 10'h3FF, 1'b0);
    send_request(ACT_READ, 8'h00, 10'd0, 1'b0);
    send_request(ACT_PUSH, 8'h55, 10'h2AA, 1'b1);
    send_request(ACT_PUSH, 8'hAA, 10'h155, 1'b0);
    send_request(ACT_PUSH, 8'h07, 10'd9, 1'b1);
    send_request(ACT_PUSH, 8'hFE, 10'h3FF, 1'b0);
    send_request(ACT_PUSH, 8'hFF, 10'd1, 1'b0);
    send_request(ACT_READ, 8'h00, 10'd0, 1'b0);
    // fill one ring past its depth so it wraps
    for (int i = 0; i < HISTORY_DEPTH + 2; i++) begin
      send_request(ACT_PUSH, 8'hAA, SAMPLE_W'(i * 97), 1'(i));
    end
    send_request(ACT_READ, 8'h00, 10'd0, 1'b1);
    req_ch.valid <= 1'b0;

    while (n_random < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
        random_request();
        n_random++;
        if (n_random == 120) hold_go <= 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d pushes and %0d reads, %0d results checked",
             n_pushes, n_reads, results_checked);
    $display("dropped pushes %0d, ring overwrites %0d, mismatches %0d",
             drops_seen, overwrites, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
